// File: rtl/core/kfv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfv_pkg : shared types and codes for the keyframe vec3 sampler
// Register indexes, result source codes, key entry layout and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package kfv_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_KEY_COUNT  = 2'd0;
	localparam logic [1:0] REG_FALLBACK_X = 2'd1;
	localparam logic [1:0] REG_FALLBACK_Y = 2'd2;
	localparam logic [1:0] REG_FALLBACK_Z = 2'd3;

	// request types
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// quotient bits of the interpolation factor, one per divider step
	localparam int unsigned DIV_STEPS = 16;

	typedef enum logic [1:0] {
		SRC_FALLBACK = 2'd0,
		SRC_FIRST    = 2'd1,
		SRC_LAST     = 2'd2,
		SRC_LERP     = 2'd3
	} src_t;

	typedef enum logic [1:0] {
		RES_FALLBACK = 2'd0,
		RES_READ     = 2'd1,
		RES_LERP     = 2'd2
	} res_sel_t;

	typedef struct packed {
		logic [31:0]        ticks;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} key_t;

	typedef struct packed {
		logic     cap;
		logic     wr_en;
		logic     rd_en;
		logic     save_prev;
		logic     div_init;
		logic     div_step;
		logic     diff;
		logic     mul;
		logic     res_load;
		res_sel_t res_sel;
		src_t     src;
	} cmd_t;

	typedef struct packed {
		logic t_le;  // request time <= time of the entry just read
		logic t_ge;  // request time >= time of the entry just read
	} status_t;

endpackage

// File: rtl/core/keyframe_vec3_sampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyframe_vec3_sampler : linear keyframe sampler for three-component values
// Stores up to MAX_KEYS keys (Q16.16 time, signed Q16.16 xyz) and answers
// time queries with the clamped or linearly interpolated vector, or fallback.
// ----------------------------------------------------------------------------
//
//  Channel   | Handshake                 | Payload
//  ----------+---------------------------+-----------------------------------
//  request   | start, busy               | req_type, key_slot, time_ticks,
//            |                           | value_x, value_y, value_z
//  result    | done (one-cycle strobe)   | sample_x/y/z, sample_source
//  config    | cfg_valid, cfg_ready      | cfg_index, cfg_data
//
//  A key load writes the table, leaves the sequencer idle and gives no
//  result. A query returns the fallback on an empty table, the first key
//  when clamped to it, or the last key when clamped to that; otherwise it
//  scans the table for the span that holds the time through the single
//  read port of the key table (one key per cycle in the scan), runs the
//  16-step restoring divider for the factor and then the difference,
//  multiply and add stages. The result registers hold their value until the
//  next query completes; the receiver cannot stall, so done is a single-cycle
//  strobe. Reset clears the control state and configuration registers; the
//  key table is undefined until written. cfg_ready is always high.
//
module keyframe_vec3_sampler #(
	parameter int MAX_KEYS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               req_type,
	input  logic [3:0]         key_slot,
	input  logic [31:0]        time_ticks,
	input  logic signed [31:0] value_x,
	input  logic signed [31:0] value_y,
	input  logic signed [31:0] value_z,
	output logic               done,
	output logic signed [31:0] sample_x,
	output logic signed [31:0] sample_y,
	output logic signed [31:0] sample_z,
	output logic [1:0]         sample_source,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	localparam int AW = $clog2(MAX_KEYS);

	logic [4:0]         key_count_q;
	logic signed [31:0] fallback_x_q, fallback_y_q, fallback_z_q;

	kfv_pkg::cmd_t    cmd;
	kfv_pkg::status_t status;
	logic [AW-1:0]    rd_addr;

	// configuration registers: always ready, take every write at once
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q  <= '0;
			fallback_x_q <= '0;
			fallback_y_q <= '0;
			fallback_z_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				kfv_pkg::REG_KEY_COUNT:  key_count_q  <= cfg_data[4:0];
				kfv_pkg::REG_FALLBACK_X: fallback_x_q <= cfg_data;
				kfv_pkg::REG_FALLBACK_Y: fallback_y_q <= cfg_data;
				kfv_pkg::REG_FALLBACK_Z: fallback_z_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// sequencer: accept, scan the table, step the divider, strobe the result
	kfv_ctrl #(
		.MAX_KEYS (MAX_KEYS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req_type  (req_type),
		.key_count (key_count_q),
		.status    (status),
		.cmd       (cmd),
		.rd_addr   (rd_addr),
		.busy      (busy),
		.done      (done)
	);

	// key table, divider and interpolation arithmetic
	kfv_datapath #(
		.MAX_KEYS (MAX_KEYS)
	) u_datapath (
		.clk           (clk),
		.cmd           (cmd),
		.rd_addr       (rd_addr),
		.status        (status),
		.key_slot      (key_slot),
		.time_ticks    (time_ticks),
		.value_x       (value_x),
		.value_y       (value_y),
		.value_z       (value_z),
		.fallback_x    (fallback_x_q),
		.fallback_y    (fallback_y_q),
		.fallback_z    (fallback_z_q),
		.sample_x      (sample_x),
		.sample_y      (sample_y),
		.sample_z      (sample_z),
		.sample_source (sample_source)
	);

endmodule

// File: rtl/core/kfv_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfv_datapath : key table, divider and interpolator
// Holds the key memory, the scan registers, a restoring divider for the
// Q0.16 factor and the multiply / add stages of the interpolation.
// ----------------------------------------------------------------------------
module kfv_datapath #(
	parameter int MAX_KEYS = 16
) (
	input  logic                clk,
	input  kfv_pkg::cmd_t       cmd,
	input  logic [$clog2(MAX_KEYS)-1:0] rd_addr,
	output kfv_pkg::status_t    status,
	input  logic [3:0]          key_slot,
	input  logic [31:0]         time_ticks,
	input  logic signed [31:0]  value_x,
	input  logic signed [31:0]  value_y,
	input  logic signed [31:0]  value_z,
	input  logic signed [31:0]  fallback_x,
	input  logic signed [31:0]  fallback_y,
	input  logic signed [31:0]  fallback_z,
	output logic signed [31:0]  sample_x,
	output logic signed [31:0]  sample_y,
	output logic signed [31:0]  sample_z,
	output logic [1:0]          sample_source
);

	localparam int AW = $clog2(MAX_KEYS);

	kfv_pkg::key_t key_mem_q [MAX_KEYS];
	kfv_pkg::key_t rd_q;
	kfv_pkg::key_t prev_q;
	logic [31:0]   t_q;

	logic [32:0]   rem_q;
	logic [31:0]   dvs_q;
	logic [15:0]   quo_q;
	logic          fzero_q;

	logic signed [32:0] diff_q [3];
	logic signed [49:0] prod_q [3];

	logic signed [31:0] res_x_q, res_y_q, res_z_q;
	logic [1:0]         src_q;

	logic        slot_ok;
	logic [32:0] rem_sh;
	logic        rem_ge;
	logic [15:0] fac;
	logic        span_ok;

	assign slot_ok = 32'(key_slot) < MAX_KEYS;

	// key memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.wr_en && slot_ok) begin
			key_mem_q[AW'(key_slot)] <= '{ticks: time_ticks, x: value_x, y: value_y,
				z: value_z};
		end
		if (cmd.rd_en) begin
			rd_q <= key_mem_q[rd_addr];
		end
	end

	assign status.t_le = t_q <= rd_q.ticks;
	assign status.t_ge = t_q >= rd_q.ticks;

	assign span_ok = (rd_q.ticks > prev_q.ticks) && (t_q >= prev_q.ticks);
	assign rem_sh  = {rem_q[31:0], 1'b0};
	assign rem_ge  = rem_sh >= {1'b0, dvs_q};
	assign fac     = fzero_q ? 16'd0 : quo_q;

	// scan, divide and interpolate registers
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			t_q <= time_ticks;
		end
		if (cmd.save_prev) begin
			prev_q <= rd_q;
		end
		if (cmd.div_init) begin
			rem_q   <= {1'b0, t_q - prev_q.ticks};
			dvs_q   <= rd_q.ticks - prev_q.ticks;
			quo_q   <= '0;
			fzero_q <= !span_ok;
		end else if (cmd.div_step) begin
			rem_q <= rem_ge ? rem_sh - {1'b0, dvs_q} : rem_sh;
			quo_q <= {quo_q[14:0], rem_ge};
		end
		if (cmd.diff) begin
			diff_q[0] <= {rd_q.x[31], rd_q.x} - {prev_q.x[31], prev_q.x};
			diff_q[1] <= {rd_q.y[31], rd_q.y} - {prev_q.y[31], prev_q.y};
			diff_q[2] <= {rd_q.z[31], rd_q.z} - {prev_q.z[31], prev_q.z};
		end
		if (cmd.mul) begin
			for (int c = 0; c < 3; c++) begin
				prod_q[c] <= diff_q[c] * $signed({1'b0, fac});
			end
		end
		if (cmd.res_load) begin
			src_q <= cmd.src;
			case (cmd.res_sel)
				kfv_pkg::RES_FALLBACK: begin
					res_x_q <= fallback_x;
					res_y_q <= fallback_y;
					res_z_q <= fallback_z;
				end
				kfv_pkg::RES_READ: begin
					res_x_q <= rd_q.x;
					res_y_q <= rd_q.y;
					res_z_q <= rd_q.z;
				end
				default: begin
					// floor of the product over 2^16, wrapped to 32 bits
					res_x_q <= prev_q.x + prod_q[0][47:16];
					res_y_q <= prev_q.y + prod_q[1][47:16];
					res_z_q <= prev_q.z + prod_q[2][47:16];
				end
			endcase
		end
	end

	assign sample_x      = res_x_q;
	assign sample_y      = res_y_q;
	assign sample_z      = res_z_q;
	assign sample_source = src_q;

endmodule

// File: rtl/core/kfv_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfv_ctrl : request sequencer
// Accepts requests, walks the key table through the read port, runs the
// divider steps and the interpolation stages, and strobes each result.
// ----------------------------------------------------------------------------
module kfv_ctrl #(
	parameter int MAX_KEYS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                req_type,
	input  logic [4:0]          key_count,
	input  kfv_pkg::status_t    status,
	output kfv_pkg::cmd_t       cmd,
	output logic [$clog2(MAX_KEYS)-1:0] rd_addr,
	output logic                busy,
	output logic                done
);

	localparam int AW  = $clog2(MAX_KEYS);
	localparam int NW0 = $clog2(MAX_KEYS + 1);
	localparam int NW  = (NW0 > 5) ? NW0 : 5;

	typedef enum logic [3:0] {
		S_IDLE, S_FALLBACK, S_FIRST, S_LAST, S_SCAN, S_DIV, S_DIFF, S_MUL, S_ADD
	} state_t;

	state_t        state_q, state_d;
	logic [AW-1:0] idx_q, idx_d;
	logic [4:0]    div_cnt_q, div_cnt_d;
	logic          done_q, done_d;

	logic [NW-1:0] n_eff;
	logic [AW-1:0] last_idx;

	assign n_eff    = (32'(key_count) > MAX_KEYS) ? NW'(MAX_KEYS) : NW'(key_count);
	assign last_idx = AW'(n_eff - NW'(1));

	always_comb begin
		cmd       = '0;
		rd_addr   = '0;
		state_d   = state_q;
		idx_d     = idx_q;
		div_cnt_d = div_cnt_q;
		done_d    = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.cap = 1'b1;
					if (req_type == kfv_pkg::REQ_LOAD) begin
						cmd.wr_en = 1'b1;
					end else begin
						cmd.rd_en = 1'b1;
						state_d   = (n_eff == '0) ? S_FALLBACK : S_FIRST;
					end
				end
			end
			S_FALLBACK: begin
				cmd.res_load = 1'b1;
				cmd.res_sel  = kfv_pkg::RES_FALLBACK;
				cmd.src      = kfv_pkg::SRC_FALLBACK;
				done_d       = 1'b1;
				state_d      = S_IDLE;
			end
			S_FIRST: begin
				if (status.t_le) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = kfv_pkg::RES_READ;
					cmd.src      = kfv_pkg::SRC_FIRST;
					done_d       = 1'b1;
					state_d      = S_IDLE;
				end else begin
					cmd.save_prev = 1'b1;
					cmd.rd_en     = 1'b1;
					rd_addr       = last_idx;
					state_d       = S_LAST;
				end
			end
			S_LAST: begin
				if (status.t_ge) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = kfv_pkg::RES_READ;
					cmd.src      = kfv_pkg::SRC_LAST;
					done_d       = 1'b1;
					state_d      = S_IDLE;
				end else begin
					cmd.rd_en = 1'b1;
					rd_addr   = AW'(1);
					idx_d     = AW'(1);
					state_d   = S_SCAN;
				end
			end
			S_SCAN: begin
				if (!status.t_ge) begin
					cmd.div_init = 1'b1;
					div_cnt_d    = 5'(kfv_pkg::DIV_STEPS);
					state_d      = S_DIV;
				end else if (idx_q == last_idx) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = kfv_pkg::RES_READ;
					cmd.src      = kfv_pkg::SRC_LERP;
					done_d       = 1'b1;
					state_d      = S_IDLE;
				end else begin
					cmd.save_prev = 1'b1;
					cmd.rd_en     = 1'b1;
					rd_addr       = idx_q + AW'(1);
					idx_d         = idx_q + AW'(1);
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				div_cnt_d    = div_cnt_q - 5'd1;
				if (div_cnt_q == 5'd1) begin
					state_d = S_DIFF;
				end
			end
			S_DIFF: begin
				cmd.diff = 1'b1;
				state_d  = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_ADD;
			end
			S_ADD: begin
				cmd.res_load = 1'b1;
				cmd.res_sel  = kfv_pkg::RES_LERP;
				cmd.src      = kfv_pkg::SRC_LERP;
				done_d       = 1'b1;
				state_d      = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			idx_q     <= '0;
			div_cnt_q <= '0;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			idx_q     <= idx_d;
			div_cnt_q <= div_cnt_d;
			done_q    <= done_d;
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = done_q;

	a_done_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q != S_IDLE))
		else $error("result strobe without a request in progress");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe longer than one cycle");

	a_busy_ends_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done_q)
		else $error("query finished without a result");

	a_busy_needs_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("sequencer left idle without a request");

endmodule
